// ===== hw/rtl/rpeg_pkg.sv =====
// rpeg_pkg: shared types, constants and small decode tables of the polygon edge generator
// no dependencies; used by rpeg_recip and the top level

package rpeg_pkg;

    localparam int RADIUS_W  = 8;
    localparam int SIDE_W    = 7;
    localparam int COORD_W   = 17;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDES  = 1'b1;

    // reset values of the configuration registers
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd10;
    localparam logic [SIDE_W-1:0]   SIDES_RST  = 7'd60;
    localparam logic [SIDE_W-1:0]   SIDES_MIN  = 7'd3;
    localparam logic [SIDE_W-1:0]   SIDES_TRI  = 7'd3;
    localparam logic [SIDE_W-1:0]   SIDES_SQR  = 7'd4;

    // fixed-point constants, unsigned q30
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [63:0] X_RND    = 64'h0000_0000_4000_0000;
    localparam logic [63:0] X2_RND   = 64'h0000_0000_2000_0000;
    localparam logic [15:0] COORD_MAX = 16'hFFFF;

    // sequencer step numbers inside one vertex
    localparam logic [STEP_W-1:0] STEP_ANG  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SQR  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_X2   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_SIN  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_COS0 = 5'd10;
    localparam logic [STEP_W-1:0] STEP_RADX = 5'd19;
    localparam logic [STEP_W-1:0] STEP_RADY = 5'd20;
    localparam logic [STEP_W-1:0] STEP_DONE = 5'd21;
    localparam logic [STEP_W-1:0] STEP_A0   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ONE  = 5'd1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_VERT  = 4'b0100,
        ST_CLOSE = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        OP_ANG,
        OP_SQR,
        OP_X2,
        OP_A,
        OP_B,
        OP_SIN,
        OP_COS0,
        OP_RADX,
        OP_RADY,
        OP_DONE
    } op_t;

    function automatic op_t op_decode(input logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            STEP_ANG:  op = OP_ANG;
            STEP_SQR:  op = OP_SQR;
            STEP_X2:   op = OP_X2;
            STEP_SIN:  op = OP_SIN;
            STEP_COS0: op = OP_COS0;
            STEP_RADX: op = OP_RADX;
            STEP_RADY: op = OP_RADY;
            STEP_DONE: op = OP_DONE;
            default:   op = step[0] ? OP_A : OP_B;
        endcase
        return op;
    endfunction

    // taylor divisors 72 42 20 6 (sine) then 90 56 30 12 2 (cosine):
    // pre shift by the power of two, then exact reciprocal multiply and post shift
    function automatic logic [1:0] div_pre(input logic [3:0] idx);
        logic [1:0] sh;
        case (idx)
            4'd0:    sh = 2'd3;
            4'd1:    sh = 2'd1;
            4'd2:    sh = 2'd2;
            4'd3:    sh = 2'd1;
            4'd4:    sh = 2'd1;
            4'd5:    sh = 2'd3;
            4'd6:    sh = 2'd1;
            4'd7:    sh = 2'd2;
            4'd8:    sh = 2'd1;
            default: sh = 2'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [31:0] div_recip(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd1908874354;
            4'd1:    r = 32'd1636178018;
            4'd2:    r = 32'd1717986919;
            4'd3:    r = 32'd1431655766;
            4'd4:    r = 32'd1527099484;
            4'd5:    r = 32'd1227133514;
            4'd6:    r = 32'd1145324613;
            4'd7:    r = 32'd1431655766;
            4'd8:    r = 32'd1073741824;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] div_post(input logic [3:0] idx);
        logic [5:0] s;
        case (idx)
            4'd0:    s = 6'd34;
            4'd1:    s = 6'd35;
            4'd2:    s = 6'd33;
            4'd3:    s = 6'd32;
            4'd4:    s = 6'd36;
            4'd5:    s = 6'd33;
            4'd6:    s = 6'd34;
            4'd7:    s = 6'd32;
            4'd8:    s = 6'd30;
            default: s = 6'd30;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/rpeg_mul.sv =====
// rpeg_mul: shared 32x32 multiplier with a registered product
// no package dependencies

module rpeg_mul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/rpeg_recip.sv =====
// rpeg_recip: restoring divider, one quotient bit per cycle, for one turn / side count
// depends on rpeg_pkg

module rpeg_recip #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [rpeg_pkg::SIDE_W-1:0]  divisor,
    output logic                         done,
    output logic [ANGLE_BITS-1:0]        quot,
    output logic [rpeg_pkg::SIDE_W-1:0]  rem
);

    localparam int CW = $clog2(ANGLE_BITS + 1);

    logic                        run_reg;
    logic                        done_reg;
    logic [CW-1:0]               cnt_reg;
    logic [rpeg_pkg::SIDE_W-1:0] rem_reg;
    logic [rpeg_pkg::SIDE_W-1:0] div_reg;
    logic [ANGLE_BITS-1:0]       quot_reg;

    logic                        num_bit;
    logic [rpeg_pkg::SIDE_W:0]   trial;
    logic [rpeg_pkg::SIDE_W:0]   diff;
    logic                        fits;

    // numerator is a single one at bit ANGLE_BITS
    assign num_bit = (cnt_reg == CW'(ANGLE_BITS));
    assign trial   = {rem_reg, num_bit};
    assign fits    = (trial >= {1'b0, div_reg});
    assign diff    = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(ANGLE_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? diff[rpeg_pkg::SIDE_W-1:0] : trial[rpeg_pkg::SIDE_W-1:0];
            quot_reg <= {quot_reg[ANGLE_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/regular_polygon_edge_generator_unit.sv =====
// regular polygon edge generator: on a draw request emits every edge of a regular polygon
// the turn/n divider runs first, then each vertex is worked out step by step on one multiplier
// busy covers the divide and every vertex and falls as the closing edge comes out
// one edge beat per vertex after the first, closing edge in the cycle after the last vertex's beat
// results are one-cycle strobes that the receiver cannot stall; rst_n clears control and config
// depends on rpeg_pkg, rpeg_recip, rpeg_mul

module regular_polygon_edge_generator_unit #(
    parameter int MAX_SIDES  = 64,
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  draw_request,
    input  logic                                  cfg_write,
    input  logic [rpeg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rpeg_pkg::RADIUS_W-1:0]         cfg_data,
    output logic                                  strobe,
    output logic signed [rpeg_pkg::COORD_W-1:0]   start_x,
    output logic signed [rpeg_pkg::COORD_W-1:0]   start_y,
    output logic signed [rpeg_pkg::COORD_W-1:0]   end_x,
    output logic signed [rpeg_pkg::COORD_W-1:0]   end_y,
    output logic                                  last_edge
);

    localparam int K_W = $clog2(MAX_SIDES);
    localparam int ASH = 32 - ANGLE_BITS;          // phase to 32-bit turn
    localparam int AW  = ANGLE_BITS - 2;           // folded octant angle incl. the span itself
    localparam logic [63:0] SC_RND = 64'd1 << (29 - FRAC_BITS);

    // configuration registers
    logic [rpeg_pkg::RADIUS_W-1:0] radius_reg;
    logic [rpeg_pkg::SIDE_W-1:0]   sides_reg;

    // sequencer
    rpeg_pkg::state_t              state_reg, state_next;
    logic [rpeg_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [K_W-1:0]                k_reg, k_next;
    logic [rpeg_pkg::SIDE_W-1:0]   n_reg, n_next;
    logic [ANGLE_BITS-1:0]         qacc_reg, qacc_next;   // k*turn/n, rounded to nearest
    logic [rpeg_pkg::SIDE_W-1:0]   racc_reg, racc_next;   // remainder, starts at n/2
    logic                          strobe_reg, strobe_next;
    logic                          last_reg, last_next;

    // datapath registers
    logic [29:0]                   x_reg;
    logic [29:0]                   x2_reg;
    logic [30:0]                   sin_reg;
    logic [30:0]                   magy_reg;
    logic                          negx_reg;
    logic                          negy_reg;
    logic [rpeg_pkg::COORD_W-1:0]  vx_reg;
    logic [rpeg_pkg::COORD_W-1:0]  v0x_reg, v0y_reg;
    logic [rpeg_pkg::COORD_W-1:0]  prevx_reg, prevy_reg;
    logic [rpeg_pkg::COORD_W-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;

    // shared units
    logic                          div_go;
    logic                          div_done;
    logic [ANGLE_BITS-1:0]         div_quot;
    logic [rpeg_pkg::SIDE_W-1:0]   div_rem;
    logic                          mul_en;
    logic [31:0]                   mul_a, mul_b;
    logic [63:0]                   prod;

    // decode and combinational datapath
    rpeg_pkg::op_t                 op;
    logic                          accept;
    logic [rpeg_pkg::SIDE_W-1:0]   n_clamp;
    logic [ANGLE_BITS-1:0]         ph_start;
    logic [ANGLE_BITS-1:0]         ph;
    logic [2:0]                    oct;
    logic [ANGLE_BITS-4:0]         fl;
    logic [AW-1:0]                 g;
    logic [63:0]                   xw;
    logic [29:0]                   x_new;
    logic [63:0]                   x2w;
    logic [29:0]                   x2_new;
    logic [29:0]                   m_new;
    logic [rpeg_pkg::STEP_W-1:0]   a_sel;
    logic [rpeg_pkg::STEP_W-1:0]   b_sel;
    logic [3:0]                    a_idx;
    logic [3:0]                    b_idx;
    logic [63:0]                   q_div;
    logic [30:0]                   s_new;
    logic [29:0]                   b_src;
    logic [29:0]                   b_opnd;
    logic [30:0]                   c0, s0, magx, magy;
    logic                          neg_sel;
    logic [63:0]                   sw;
    logic [63:0]                   r_full;
    logic [15:0]                   r16;
    logic [rpeg_pkg::COORD_W-1:0]  coord;
    logic                          k_last;
    logic [rpeg_pkg::SIDE_W:0]     r_sum;
    logic                          wrap;
    logic [rpeg_pkg::SIDE_W:0]     r_wrap;
    logic                          emit_vert;

    assign busy   = (state_reg != rpeg_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign div_go = accept && draw_request;

    // side count outside 3..MAX_SIDES is pulled to the nearest end
    always_comb
    begin
        if (sides_reg < rpeg_pkg::SIDES_MIN)
        begin
            n_clamp = rpeg_pkg::SIDES_MIN;
        end
        else if (sides_reg > rpeg_pkg::SIDE_W'(MAX_SIDES))
        begin
            n_clamp = rpeg_pkg::SIDE_W'(MAX_SIDES);
        end
        else
        begin
            n_clamp = sides_reg;
        end
    end

    rpeg_recip #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .divisor (n_clamp),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    rpeg_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // phase of the current vertex: quarter turn for triangles, eighth turn for squares
    always_comb
    begin
        if (n_reg == rpeg_pkg::SIDES_TRI)
        begin
            ph_start = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
        end
        else if (n_reg == rpeg_pkg::SIDES_SQR)
        begin
            ph_start = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
        end
        else
        begin
            ph_start = '0;
        end
    end

    assign ph  = qacc_reg + ph_start;
    assign oct = ph[ANGLE_BITS-1 -: 3];
    assign fl  = ph[ANGLE_BITS-4:0];
    // odd octants measure from the next quarter turn
    assign g   = oct[0] ? ((AW'(1) << (ANGLE_BITS - 3)) - {1'b0, fl}) : {1'b0, fl};

    // radians in q30 from the angle product, then x squared
    assign xw     = (prod << ASH) + rpeg_pkg::X_RND;
    assign x_new  = xw[60:31];
    assign x2w    = prod + rpeg_pkg::X2_RND;
    assign x2_new = x2w[59:30];
    assign m_new  = prod[59:30];

    assign op    = rpeg_pkg::op_decode(step_reg);
    // odd steps finish a taylor term, even steps start the divide
    assign a_sel = (step_reg - rpeg_pkg::STEP_A0) >> 1;
    assign b_sel = (step_reg >> 1) - rpeg_pkg::STEP_ONE;
    assign a_idx = a_sel[3:0];
    assign b_idx = b_sel[3:0];

    // term = 1 - (x2*t)/d, divide done as exact reciprocal multiply
    assign q_div = prod >> rpeg_pkg::div_post(a_idx);
    assign s_new = rpeg_pkg::Q30_ONE - q_div[30:0];

    always_comb
    begin
        case (op)
            rpeg_pkg::OP_X2:   b_src = x2_new;
            rpeg_pkg::OP_COS0: b_src = x2_reg;
            default:           b_src = m_new;
        endcase
    end

    assign b_opnd = b_src >> rpeg_pkg::div_pre(b_idx);

    // octant swap then quadrant signs; s_new holds the cosine at the x radius step
    assign c0      = oct[0] ? sin_reg : s_new;
    assign s0      = oct[0] ? s_new : sin_reg;
    assign magx    = oct[1] ? s0 : c0;
    assign magy    = oct[1] ? c0 : s0;

    // radius scaling, round half away from zero, saturate
    assign neg_sel = (op == rpeg_pkg::OP_RADY) ? negx_reg : negy_reg;
    assign sw      = prod + SC_RND;
    assign r_full  = sw >> (30 - FRAC_BITS);
    assign r16     = (r_full > 64'(rpeg_pkg::COORD_MAX)) ? rpeg_pkg::COORD_MAX : r_full[15:0];
    assign coord   = neg_sel ? -{1'b0, r16} : {1'b0, r16};

    // next vertex phase: carry remainder, bump quotient on wrap
    assign k_last = (rpeg_pkg::SIDE_W'(k_reg) == (n_reg - 1'b1));
    assign r_sum  = {1'b0, racc_reg} + {1'b0, div_rem};
    assign wrap   = (r_sum >= {1'b0, n_reg});
    assign r_wrap = wrap ? (r_sum - {1'b0, n_reg}) : r_sum;

    assign emit_vert = (state_reg == rpeg_pkg::ST_VERT) && (op == rpeg_pkg::OP_DONE)
                       && (k_reg != '0);

    // multiplier operand selection
    always_comb
    begin
        mul_en = (state_reg == rpeg_pkg::ST_VERT) && (op != rpeg_pkg::OP_DONE);
        case (op)
            rpeg_pkg::OP_ANG:
            begin
                mul_a = 32'(g);
                mul_b = rpeg_pkg::PI_Q30;
            end
            rpeg_pkg::OP_SQR:
            begin
                mul_a = 32'(x_new);
                mul_b = 32'(x_new);
            end
            rpeg_pkg::OP_A:
            begin
                mul_a = 32'(x2_reg);
                mul_b = 32'(s_new);
            end
            rpeg_pkg::OP_SIN:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(s_new);
            end
            rpeg_pkg::OP_X2, rpeg_pkg::OP_B, rpeg_pkg::OP_COS0:
            begin
                mul_a = 32'(b_opnd);
                mul_b = rpeg_pkg::div_recip(b_idx);
            end
            rpeg_pkg::OP_RADX:
            begin
                mul_a = 32'(radius_reg);
                mul_b = 32'(magx);
            end
            rpeg_pkg::OP_RADY:
            begin
                mul_a = 32'(radius_reg);
                mul_b = 32'(magy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        qacc_next   = qacc_reg;
        racc_next   = racc_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        case (state_reg)
            rpeg_pkg::ST_IDLE:
            begin
                if (div_go)
                begin
                    n_next     = n_clamp;
                    state_next = rpeg_pkg::ST_DIV;
                end
            end
            rpeg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    step_next  = '0;
                    k_next     = '0;
                    qacc_next  = '0;
                    racc_next  = n_reg >> 1;
                    state_next = rpeg_pkg::ST_VERT;
                end
            end
            rpeg_pkg::ST_VERT:
            begin
                if (op == rpeg_pkg::OP_DONE)
                begin
                    strobe_next = (k_reg != '0);
                    if (k_last)
                    begin
                        state_next = rpeg_pkg::ST_CLOSE;
                    end
                    else
                    begin
                        step_next = '0;
                        k_next    = k_reg + 1'b1;
                        racc_next = r_wrap[rpeg_pkg::SIDE_W-1:0];
                        qacc_next = qacc_reg + div_quot + ANGLE_BITS'(wrap);
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            rpeg_pkg::ST_CLOSE:
            begin
                // closing edge back to vertex 0
                strobe_next = 1'b1;
                last_next   = 1'b1;
                state_next  = rpeg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rpeg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rpeg_pkg::ST_IDLE;
            step_reg   <= '0;
            k_reg      <= '0;
            n_reg      <= rpeg_pkg::SIDES_MIN;
            qacc_reg   <= '0;
            racc_reg   <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            k_reg      <= k_next;
            n_reg      <= n_next;
            qacc_reg   <= qacc_next;
            racc_reg   <= racc_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rpeg_pkg::RADIUS_RST;
            sides_reg  <= rpeg_pkg::SIDES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rpeg_pkg::REG_RADIUS: radius_reg <= cfg_data;
                rpeg_pkg::REG_SIDES:  sides_reg  <= cfg_data[rpeg_pkg::SIDE_W-1:0];
                default:              ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == rpeg_pkg::ST_VERT)
        begin
            case (op)
                rpeg_pkg::OP_SQR:  x_reg   <= x_new;
                rpeg_pkg::OP_X2:   x2_reg  <= x2_new;
                rpeg_pkg::OP_COS0: sin_reg <= prod[60:30];
                rpeg_pkg::OP_RADX:
                begin
                    magy_reg <= magy;
                    negx_reg <= oct[2] ^ oct[1];
                    negy_reg <= oct[2];
                end
                rpeg_pkg::OP_RADY: vx_reg <= coord;
                rpeg_pkg::OP_DONE:
                begin
                    prevx_reg <= vx_reg;
                    prevy_reg <= coord;
                    if (k_reg == '0)
                    begin
                        v0x_reg <= vx_reg;
                        v0y_reg <= coord;
                    end
                end
                default: ;
            endcase
        end
    end

    // output beat registers
    always_ff @(posedge clk)
    begin
        if (emit_vert)
        begin
            sx_reg <= vx_reg;
            sy_reg <= coord;
            ex_reg <= prevx_reg;
            ey_reg <= prevy_reg;
        end
        else if (state_reg == rpeg_pkg::ST_CLOSE)
        begin
            sx_reg <= v0x_reg;
            sy_reg <= v0y_reg;
            ex_reg <= prevx_reg;
            ey_reg <= prevy_reg;
        end
    end

    assign strobe    = strobe_reg;
    assign last_edge = last_reg;
    assign start_x   = sx_reg;
    assign start_y   = sy_reg;
    assign end_x     = ex_reg;
    assign end_y     = ey_reg;

endmodule

// ===== hw/rtl/rpeg_checker.sv =====
// rpeg_checker: port-level checks of the polygon edge generator
// no package dependencies; bound to regular_polygon_edge_generator_unit below

module rpeg_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic draw_request,
    input logic busy,
    input logic strobe,
    input logic last_edge
);

    // every edge beat comes out of a busy period
    a_beat_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("edge beat without a busy period");

    // only the closing edge coincides with the return to idle
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (busy != last_edge))
        else $error("closing edge and busy disagree");

    // busy ends only with the closing edge
    a_fall_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last_edge))
        else $error("busy dropped without a closing edge");

    // an empty request leaves the block idle
    a_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !draw_request) |=> !busy)
        else $error("empty request started work");

    // work starts only on an accepted draw request
    a_rise_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && draw_request))
        else $error("busy rose without a draw request");

endmodule

bind regular_polygon_edge_generator_unit rpeg_checker u_rpeg_checker (.*);

// ===== tb/rpeg_edge_checker.sv =====
// rpeg_edge_checker: watches the command, config and edge ports of the polygon edge generator,
// predicts every edge beat and compares it with what the block puts out
// depends on rpeg_pkg for the register indexes and port widths
`timescale 1ns / 100ps

module rpeg_edge_checker #(
    parameter int MAX_SIDES  = 64,
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  draw_request,
    input  logic                                  cfg_write,
    input  logic [rpeg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rpeg_pkg::RADIUS_W-1:0]         cfg_data,
    input  logic                                  strobe,
    input  logic signed [rpeg_pkg::COORD_W-1:0]   start_x,
    input  logic signed [rpeg_pkg::COORD_W-1:0]   start_y,
    input  logic signed [rpeg_pkg::COORD_W-1:0]   end_x,
    input  logic signed [rpeg_pkg::COORD_W-1:0]   end_y,
    input  logic                                  last_edge,
    output int                                    error_count,
    output int                                    pending_count
);

    import rpeg_pkg::*;

    localparam bit [63:0] FX_ONE    = 64'd1 << 30;
    localparam bit [63:0] FX_PI     = 64'd3373259426;
    localparam bit [63:0] OCT_WIDTH = 64'd1 << 29;
    localparam bit [63:0] MAG_LIMIT = 64'd65535;
    localparam int        MAX_SHOWN = 10;

    typedef struct {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      closing;
    } edge_seg_t;

    edge_seg_t             polygon_edges[$];
    logic [RADIUS_W-1:0]   radius_reg;
    logic [SIDE_W-1:0]     sides_reg;
    int                    errors;

    // taylor divisors, innermost term first
    bit [63:0] sin_divs [4] = '{64'd72, 64'd42, 64'd20, 64'd6};
    bit [63:0] cos_divs [5] = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};

    // signed q30 unit vector of a 32-bit turn phase
    function automatic void unit_vector(input bit [31:0] turn, output longint ux,
                                        output longint uy);
        bit [2:0]  oct;
        bit [63:0] f, x, x2, s, c, cc, ss;
        oct = turn[31:29];
        f   = {35'd0, turn[28:0]};
        if (oct[0])
            f = OCT_WIDTH - f;
        x  = (f * FX_PI + FX_ONE) >> 31;
        x2 = (x * x + (FX_ONE >> 1)) >> 30;
        s = FX_ONE;
        foreach (sin_divs[i])
            s = FX_ONE - ((x2 * s) >> 30) / sin_divs[i];
        s = (x * s) >> 30;
        c = FX_ONE;
        foreach (cos_divs[i])
            c = FX_ONE - ((x2 * c) >> 30) / cos_divs[i];
        // odd octants swap the roles of sine and cosine
        cc = oct[0] ? s : c;
        ss = oct[0] ? c : s;
        case (oct[2:1])
            2'd0:    begin ux =  longint'(cc); uy =  longint'(ss); end
            2'd1:    begin ux = -longint'(ss); uy =  longint'(cc); end
            2'd2:    begin ux = -longint'(cc); uy = -longint'(ss); end
            default: begin ux =  longint'(ss); uy = -longint'(cc); end
        endcase
    endfunction

    // radius times unit component, rounded half away from zero, saturated
    function automatic logic signed [COORD_W-1:0] scale_coord(input longint u,
                                                              input bit [7:0] rad);
        bit [63:0] mag, r;
        mag = (u < 0) ? 64'(-u) : 64'(u);
        r   = (64'(rad) * mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (r > MAG_LIMIT)
            r = MAG_LIMIT;
        return (u < 0) ? -COORD_W'(r) : COORD_W'(r);
    endfunction

    // queue every edge of the polygon that the current registers describe
    function automatic void predict_polygon();
        logic signed [COORD_W-1:0] vert_x [MAX_SIDES];
        logic signed [COORD_W-1:0] vert_y [MAX_SIDES];
        int unsigned               n, full, first_ph, ph, nxt;
        longint                    ux, uy;
        edge_seg_t                 seg;
        n = sides_reg;
        if (n < 3)
            n = 3;
        if (n > MAX_SIDES)
            n = MAX_SIDES;
        full = 1 << ANGLE_BITS;
        first_ph = (n == 3) ? full >> 2 : (n == 4) ? full >> 3 : 0;
        for (int k = 0; k < n; k++) begin
            ph = (first_ph + (k * full + n / 2) / n) & (full - 1);
            unit_vector(32'(ph << (32 - ANGLE_BITS)), ux, uy);
            vert_x[k] = scale_coord(ux, radius_reg);
            vert_y[k] = scale_coord(uy, radius_reg);
        end
        for (int k = 0; k < n; k++) begin
            nxt = (k + 1 == n) ? 0 : k + 1;
            seg.sx = vert_x[nxt];
            seg.sy = vert_y[nxt];
            seg.ex = vert_x[k];
            seg.ey = vert_y[k];
            seg.closing = (k + 1 == n);
            polygon_edges.push_back(seg);
        end
    endfunction

    function automatic void report(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        edge_seg_t want;
        if (!rst_n) begin
            radius_reg = 8'd10;
            sides_reg  = 7'd60;
            errors     = 0;
            polygon_edges.delete();
            error_count   <= 0;
            pending_count <= 0;
        end else begin
            // results are checked before a command at the same edge is predicted
            if (strobe) begin
                if (polygon_edges.size() == 0) begin
                    report($sformatf("unexpected edge beat (%0d,%0d)->(%0d,%0d) last %0b",
                                     start_x, start_y, end_x, end_y, last_edge));
                end else begin
                    want = polygon_edges.pop_front();
                    if (start_x !== want.sx || start_y !== want.sy || end_x !== want.ex ||
                        end_y !== want.ey || last_edge !== want.closing)
                        report($sformatf({"edge mismatch: exp (%0d,%0d)->(%0d,%0d) last %0b",
                                          " got (%0d,%0d)->(%0d,%0d) last %0b"},
                                         want.sx, want.sy, want.ex, want.ey, want.closing,
                                         start_x, start_y, end_x, end_y, last_edge));
                end
            end
            if (cfg_write) begin
                if (cfg_index == REG_RADIUS)
                    radius_reg = cfg_data;
                else if (cfg_index == REG_SIDES)
                    sides_reg = cfg_data[SIDE_W-1:0];
            end
            if (start && !busy && draw_request)
                predict_polygon();
            error_count   <= errors;
            pending_count <= polygon_edges.size();
        end
    end

endmodule

// ===== tb/tb_regular_polygon_edge_generator_unit.sv =====
// tb_regular_polygon_edge_generator_unit: drives draw commands and register writes into the
// polygon edge generator and gives the verdict; checking is done by rpeg_edge_checker
// depends on rpeg_pkg, rpeg_edge_checker and the generator rtl
`timescale 1ns / 100ps

module tb_regular_polygon_edge_generator_unit;

    import rpeg_pkg::*;

    // this outlasts the busy time of a 64-sided polygon, so this covers
    // any leftover work before a register write and the drain at the end
    localparam int SETTLE_CYCLES = 1600;
    // beats with a draw request in the random part
    localparam int RANDOM_DRAWS  = 100;
    // generous cap on the simulated run time, in ns
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          draw_request = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = REG_RADIUS;
    logic [RADIUS_W-1:0]           cfg_data = '0;
    logic                          busy;
    logic                          strobe;
    logic signed [COORD_W-1:0]     start_x;
    logic signed [COORD_W-1:0]     start_y;
    logic signed [COORD_W-1:0]     end_x;
    logic signed [COORD_W-1:0]     end_y;
    logic                          last_edge;
    int                            fail_count;
    int                            pending;

    // idling style of the current phase: no gaps at all, or random gaps
    bit                            allow_gaps;
    int                            drawn;

    // directed register settings: triangle and square start angles, full radius,
    // zero radius, largest polygon, side counts below three and above the maximum,
    // and a sides write with the top data bit set
    bit [7:0] dir_radius [8] = '{8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd200, 8'd3, 8'd77};
    bit [7:0] dir_sides  [8] = '{8'd3,   8'd4, 8'd64,  8'd0,   8'd2, 8'd65,  8'hFF, 8'd5};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    regular_polygon_edge_generator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .draw_request (draw_request),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .last_edge    (last_edge)
    );

    rpeg_edge_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .draw_request  (draw_request),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .strobe        (strobe),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .last_edge     (last_edge),
        .error_count   (fail_count),
        .pending_count (pending)
    );

    // idle cycles ahead of a command: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (!allow_gaps || roll < 11)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // one command beat; start is left high so a back-to-back command needs no
    // second assignment in the same step
    task automatic send_draw(input bit req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
                // the payload is don't-care while start is low, so drive it at random
                draw_request <= $urandom_range(0, 1);
            end
        end
        start        <= 1'b1;
        draw_request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    // wait for all edges to arrive, then let a no-result command finish too
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // both registers, back to back, only while the block is idle
    task automatic write_config(input bit [7:0] rad, input bit [7:0] sides);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_RADIUS;
        cfg_data  <= rad;
        @(posedge clk);
        cfg_index <= REG_SIDES;
        cfg_data  <= sides;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= $urandom_range(0, 255);
    endtask

    // polygon size after the block's clamping, used only to keep big polygons rare
    function automatic int clamped_sides(input bit [7:0] sides);
        int n;
        n = sides[6:0];
        if (n < 3)
            n = 3;
        if (n > 64)
            n = 64;
        return n;
    endfunction

    initial
    begin
        bit [7:0] rad, sides;
        int       beats;
        bit       req;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset values first: request, no request, request
        allow_gaps = 1'b0;
        send_draw(1'b1);
        send_draw(1'b0);
        send_draw(1'b1);
        allow_gaps = 1'b1;
        foreach (dir_radius[i]) begin
            write_config(dir_radius[i], dir_sides[i]);
            send_draw(1'b1);
            if (i == 0) begin
                send_draw(1'b0);
                send_draw(1'b1);
            end
        end

        // random part: mostly small polygons, occasionally extreme settings
        drawn = 0;
        while (drawn < RANDOM_DRAWS) begin
            case ($urandom_range(0, 9))
                0:       rad = 8'd0;
                1:       rad = 8'd255;
                default: rad = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 19))
                0:       sides = $urandom_range(0, 2);
                1:       sides = $urandom_range(13, 64);
                2:       sides = $urandom_range(65, 255);
                3:       sides = 8'd3;
                4:       sides = 8'd4;
                default: sides = $urandom_range(3, 12);
            endcase
            write_config(rad, sides);
            allow_gaps = ($urandom_range(0, 3) != 0);
            beats = (clamped_sides(sides) > 16) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            repeat (beats)
            begin
                req = ($urandom_range(0, 5) != 0);
                send_draw(req);
                if (req)
                    drawn++;
            end
        end

        // drain: nothing outstanding, then the settle time once more
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #RUN_LIMIT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule
